@@ hdl/bts_pkg.sv @@
// ----------------------------------------------------------------------------
// bts_pkg: shared constants for the bilinear texture sampler
// Field widths, fixed-point constants, item kinds and register indexes.
// ----------------------------------------------------------------------------
package bts_pkg;

  localparam int TEXEL_CAPACITY = 65536;
  localparam int MAX_DIMENSION  = 256;

  localparam int ADDR_W   = 16;  // texel address
  localparam int TEXEL_W  = 17;  // unsigned Q1.16
  localparam int COORD_W  = 20;  // signed Q4.16
  localparam int DIM_W    = 9;   // texture width or height
  localparam int IDX_W    = 8;   // clamped texel column or row
  localparam int FRAC_W   = 16;
  localparam int POS_W    = 30;  // texel-space position, signed, 16 fraction bits
  localparam int BASE_W   = POS_W - FRAC_W;
  localparam int PROD1_W  = 33;  // first blend level, 32 fraction bits
  localparam int PROD2_W  = 49;  // second blend level, 48 fraction bits
  localparam int CFG_IDX_W = 1;

  localparam logic [TEXEL_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [DIM_W-1:0]   DIM_LIMIT = DIM_W'(MAX_DIMENSION);
  localparam logic signed [POS_W-1:0] HALF_TEXEL = 30'sd32768;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 1'd1;

  localparam int NUM_STAGES = 8;

endpackage

@@ hdl/bts_ram.sv @@
// ----------------------------------------------------------------------------
// bts_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low.
// ----------------------------------------------------------------------------
module bts_ram #(
  parameter int DATA_W = 17,
  parameter int DEPTH  = 65536,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/bilinear_texture_sampler_core.sv @@
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_core: bilinear texture filter, clamp to edge
// Single-channel texture store with texel writes and bilinear sample reads.
// ----------------------------------------------------------------------------
//  Channel | Handshake          | Payload
//  --------+--------------------+-----------------------------------------------
//  in_     | in_valid/in_stall  | kind, texel_address, texel_value, u/v_coord
//  out_    | out_valid/out_stall| sample_value (one per sample, none per write)
//  cfg_    | cfg_valid/cfg_ready| index 0 = width, 1 = height; cfg_ready is high
//
//  One transaction per cycle in and one result per cycle out while neither side stalls.
//  The four corner reads come from four copies of the texel store, one per
//  corner, each a one-read one-write RAM; every texel write goes to all four.
//  Writes and reads happen in the same stage, so items keep their order.
//  Reset clears the pipeline and both size registers; the texel store has no
//  reset and no clearing pass. A stall on the output fills the empty stages
//  first; in_stall rises only when all eight stages hold an item.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [bts_pkg::ADDR_W-1:0]       in_texel_address,
  input  logic [bts_pkg::TEXEL_W-1:0]      in_texel_value,
  input  logic signed [bts_pkg::COORD_W-1:0] in_u_coord,
  input  logic signed [bts_pkg::COORD_W-1:0] in_v_coord,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bts_pkg::TEXEL_W-1:0]      out_sample_value,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bts_pkg::DIM_W-1:0]        cfg_data
);

  import bts_pkg::*;

  // Clamps a corner index to [0, size - 1].
  function automatic logic [IDX_W-1:0] clamp_idx(input logic signed [BASE_W-1:0] b,
                                                 input logic [DIM_W-1:0] size);
    logic [DIM_W-1:0] hi;
    logic [IDX_W-1:0] res;
    hi = size - 9'd1;
    if (b < 0) begin
      res = '0;
    end else if (b > $signed({{(BASE_W-DIM_W){1'b0}}, hi})) begin
      res = hi[IDX_W-1:0];
    end else begin
      res = b[IDX_W-1:0];
    end
    return res;
  endfunction

  // Size registers
  logic [DIM_W-1:0] width_r, height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TEXTURE_WIDTH:  width_r  <= (cfg_data > DIM_LIMIT) ? DIM_LIMIT : cfg_data;
        CFG_TEXTURE_HEIGHT: height_r <= (cfg_data > DIM_LIMIT) ? DIM_LIMIT : cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage loads when it is empty or the next one loads.
  logic [NUM_STAGES:1] v_r;
  logic [NUM_STAGES:1] v_nxt;
  logic [NUM_STAGES:1] en;

  always_comb begin
    en[NUM_STAGES] = !v_r[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[1];

  // Stage 1: texel-space positions and the saturated write value.
  logic                     s1_samp_r, s1_notex_r;
  logic signed [POS_W-1:0]  s1_pos_u_r, s1_pos_v_r;
  logic [ADDR_W-1:0]        s1_waddr_r;
  logic [TEXEL_W-1:0]       s1_wval_r;
  logic signed [POS_W-1:0]  u_ext, v_ext, w_ext, h_ext;

  always_comb begin
    u_ext = {{(POS_W-COORD_W){in_u_coord[COORD_W-1]}}, in_u_coord};
    v_ext = {{(POS_W-COORD_W){in_v_coord[COORD_W-1]}}, in_v_coord};
    w_ext = $signed({{(POS_W-DIM_W){1'b0}}, width_r});
    h_ext = $signed({{(POS_W-DIM_W){1'b0}}, height_r});
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_samp_r  <= (in_kind == KIND_SAMPLE);
      s1_notex_r <= (width_r == '0) || (height_r == '0);
      s1_pos_u_r <= u_ext * w_ext - HALF_TEXEL;
      s1_pos_v_r <= v_ext * h_ext - HALF_TEXEL;
      s1_waddr_r <= in_texel_address;
      s1_wval_r  <= (in_texel_value > ONE_Q16) ? ONE_Q16 : in_texel_value;
    end
  end

  // Stage 2: floor, fraction and clamped corner indices.
  logic                     s2_samp_r, s2_notex_r;
  logic [IDX_W-1:0]         s2_x0_r, s2_x1_r, s2_y0_r, s2_y1_r;
  logic [FRAC_W-1:0]        s2_tx_r, s2_ty_r;
  logic [ADDR_W-1:0]        s2_waddr_r;
  logic [TEXEL_W-1:0]       s2_wval_r;
  logic signed [BASE_W-1:0] base_u, base_v;

  // The arithmetic top slice of the position is the floor of the texel index.
  assign base_u = s1_pos_u_r[POS_W-1:FRAC_W];
  assign base_v = s1_pos_v_r[POS_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_samp_r  <= s1_samp_r;
      s2_notex_r <= s1_notex_r;
      s2_x0_r    <= clamp_idx(base_u, width_r);
      s2_x1_r    <= clamp_idx(base_u + BASE_W'(1), width_r);
      s2_y0_r    <= clamp_idx(base_v, height_r);
      s2_y1_r    <= clamp_idx(base_v + BASE_W'(1), height_r);
      s2_tx_r    <= s1_pos_u_r[FRAC_W-1:0];
      s2_ty_r    <= s1_pos_v_r[FRAC_W-1:0];
      s2_waddr_r <= s1_waddr_r;
      s2_wval_r  <= s1_wval_r;
    end
  end

  // Stage 3: linear addresses of the four corners.
  localparam int RB_W = IDX_W + DIM_W;

  logic                s3_samp_r, s3_notex_r;
  logic [ADDR_W-1:0]   s3_addr_r [4];
  logic [FRAC_W-1:0]   s3_tx_r, s3_ty_r;
  logic [ADDR_W-1:0]   s3_waddr_r;
  logic [TEXEL_W-1:0]  s3_wval_r;
  logic [RB_W-1:0]     row0, row1;
  logic [RB_W-1:0]     addr_sum [4];

  always_comb begin
    row0 = RB_W'(s2_y0_r) * RB_W'(width_r);
    row1 = RB_W'(s2_y1_r) * RB_W'(width_r);
    addr_sum[0] = row0 + RB_W'(s2_x0_r);
    addr_sum[1] = row0 + RB_W'(s2_x1_r);
    addr_sum[2] = row1 + RB_W'(s2_x0_r);
    addr_sum[3] = row1 + RB_W'(s2_x1_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_samp_r  <= s2_samp_r;
      s3_notex_r <= s2_notex_r;
      for (int c = 0; c < 4; c++) begin
        s3_addr_r[c] <= addr_sum[c][ADDR_W-1:0];
      end
      s3_tx_r    <= s2_tx_r;
      s3_ty_r    <= s2_ty_r;
      s3_waddr_r <= s2_waddr_r;
      s3_wval_r  <= s2_wval_r;
    end
  end

  // Stage 4: corner texels from the four store copies.
  logic               ram_wr_en;
  logic [TEXEL_W-1:0] s4_p [4];
  logic               s4_notex_r;
  logic [FRAC_W-1:0]  s4_tx_r, s4_ty_r;

  assign ram_wr_en = v_r[3] && !s3_samp_r && en[4];

  for (genvar c = 0; c < 4; c++) begin : g_corner
    bts_ram #(
      .DATA_W (TEXEL_W),
      .DEPTH  (TEXEL_CAPACITY)
    ) u_ram (
      .clk     (clk),
      .wr_en   (ram_wr_en),
      .wr_addr (s3_waddr_r),
      .wr_data (s3_wval_r),
      .rd_en   (en[4]),
      .rd_addr (s3_addr_r[c]),
      .rd_data (s4_p[c])
    );
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_notex_r <= s3_notex_r;
      s4_tx_r    <= s3_tx_r;
      s4_ty_r    <= s3_ty_r;
    end
  end

  // Stage 5: horizontal weight products.
  localparam int MUL1_W = 2 * TEXEL_W;

  logic               s5_notex_r;
  logic [FRAC_W-1:0]  s5_ty_r;
  logic [PROD1_W-1:0] s5_m_r [4];
  logic [TEXEL_W-1:0] wx0, wx1;
  logic [MUL1_W-1:0]  m_full [4];

  always_comb begin
    wx1 = TEXEL_W'(s4_tx_r);
    wx0 = ONE_Q16 - wx1;
    m_full[0] = MUL1_W'(s4_p[0]) * MUL1_W'(wx0);
    m_full[1] = MUL1_W'(s4_p[1]) * MUL1_W'(wx1);
    m_full[2] = MUL1_W'(s4_p[2]) * MUL1_W'(wx0);
    m_full[3] = MUL1_W'(s4_p[3]) * MUL1_W'(wx1);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_notex_r <= s4_notex_r;
      s5_ty_r    <= s4_ty_r;
      for (int c = 0; c < 4; c++) begin
        s5_m_r[c] <= m_full[c][PROD1_W-1:0];
      end
    end
  end

  // Stage 6: top and bottom row blends.
  logic               s6_notex_r;
  logic [FRAC_W-1:0]  s6_ty_r;
  logic [PROD1_W-1:0] s6_top_r, s6_bot_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_notex_r <= s5_notex_r;
      s6_ty_r    <= s5_ty_r;
      s6_top_r   <= s5_m_r[0] + s5_m_r[1];
      s6_bot_r   <= s5_m_r[2] + s5_m_r[3];
    end
  end

  // Stage 7: vertical weight products.
  localparam int MUL2_W = PROD1_W + TEXEL_W;

  logic               s7_notex_r;
  logic [PROD2_W-1:0] s7_n0_r, s7_n1_r;
  logic [TEXEL_W-1:0] wy0, wy1;
  logic [MUL2_W-1:0]  n0_full, n1_full;

  always_comb begin
    wy1 = TEXEL_W'(s6_ty_r);
    wy0 = ONE_Q16 - wy1;
    n0_full = MUL2_W'(s6_top_r) * MUL2_W'(wy0);
    n1_full = MUL2_W'(s6_bot_r) * MUL2_W'(wy1);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_notex_r <= s6_notex_r;
      s7_n0_r    <= n0_full[PROD2_W-1:0];
      s7_n1_r    <= n1_full[PROD2_W-1:0];
    end
  end

  // Stage 8: final sum, round half up, saturate; output register.
  localparam int ACC_W = PROD2_W + 1;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(64'h8000_0000);

  logic [ACC_W-1:0]        acc;
  logic [ACC_W-32-1:0]     rounded;
  logic [TEXEL_W-1:0]      out_sample_value_r, out_sample_value_nxt;

  always_comb begin
    acc = ACC_W'(s7_n0_r) + ACC_W'(s7_n1_r) + ROUND_HALF;
    rounded = acc[ACC_W-1:32];
    if (s7_notex_r || (rounded > (ACC_W-32)'(ONE_Q16))) begin
      out_sample_value_nxt = ONE_Q16;
    end else begin
      out_sample_value_nxt = rounded[TEXEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_sample_value_r <= out_sample_value_nxt;
    end
  end

  assign out_valid        = v_r[NUM_STAGES];
  assign out_sample_value = out_sample_value_r;

  // Valid bits; write transactions leave the pipeline at the store stage.
  always_comb begin
    v_nxt = v_r;
    if (en[1]) begin
      v_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NUM_STAGES; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 4) ? (v_r[3] && s3_samp_r) : v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

endmodule

@@ hdl/bts_checker.sv @@
// ----------------------------------------------------------------------------
// bts_checker: port-level assertions for the bilinear texture sampler
// Watches the top-level ports and is bound to every instance of the core.
// ----------------------------------------------------------------------------
module bts_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bts_pkg::TEXEL_W-1:0] out_sample_value
);

  import bts_pkg::*;

  // A result never goes away while the receiver stalls it.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A filtered texel never exceeds 1.0.
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sample_value <= ONE_Q16)
    else $error("sample_value above 1.0");

  // The input only backs up when the whole pipeline is full behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

endmodule

bind bilinear_texture_sampler_core bts_checker u_bts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sample_value (out_sample_value)
);

@@ sim/bilinear_texture_sampler_core_tb.sv @@
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_core_tb: self-checking bench for the texture sampler
// Writes texels and size registers, issues bilinear samples, and compares
// every result with a fixed-point model of the clamp-to-edge bilinear filter.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bts_pkg::*;

  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 58;
  localparam int NUM_PHASES       = 9;

  typedef struct {
    logic signed [COORD_W-1:0] u;
    logic signed [COORD_W-1:0] v;
    logic [TEXEL_W-1:0]        value;
  } sample_expect_t;

  class bilinear_scoreboard;
    logic [TEXEL_W-1:0] texel_mirror [TEXEL_CAPACITY];
    int unsigned        cur_width;
    int unsigned        cur_height;
    sample_expect_t     pending_samples [$];
    int                 failures;
    int                 checked;

    function new();
      foreach (texel_mirror[i]) texel_mirror[i] = '0;
      cur_width  = 0;
      cur_height = 0;
      failures   = 0;
      checked    = 0;
    endfunction

    function void set_size(logic [CFG_IDX_W-1:0] index, logic [DIM_W-1:0] data);
      int unsigned dim;
      dim = (data > DIM_LIMIT) ? DIM_LIMIT : data;
      if (index == CFG_TEXTURE_WIDTH) begin
        cur_width = dim;
      end else if (index == CFG_TEXTURE_HEIGHT) begin
        cur_height = dim;
      end
    endfunction

    function longint clamp_index(longint idx, longint hi);
      if (idx < 0) return 0;
      if (idx > hi) return hi;
      return idx;
    endfunction

    // The weight comes from the unclamped position; only the indexes clamp.
    function void locate_axis(input longint coord, input longint size,
                              output longint lo, output longint hi,
                              output longint frac);
      longint pos;
      longint base;
      pos  = coord * size - longint'(HALF_TEXEL);
      base = pos >>> FRAC_W;
      frac = pos - (base <<< FRAC_W);
      lo   = clamp_index(base, size - 1);
      hi   = clamp_index(base + 1, size - 1);
    endfunction

    function logic [TEXEL_W-1:0] filter_sample(logic signed [COORD_W-1:0] u,
                                               logic signed [COORD_W-1:0] v);
      longint w, h, one;
      longint x0, x1, y0, y1, tx, ty;
      longint p00, p10, p01, p11;
      longint top, bottom, acc, rounded;
      one = longint'(ONE_Q16);
      w   = cur_width;
      h   = cur_height;
      locate_axis(longint'(u), w, x0, x1, tx);
      locate_axis(longint'(v), h, y0, y1, ty);
      p00 = texel_mirror[y0 * w + x0];
      p10 = texel_mirror[y0 * w + x1];
      p01 = texel_mirror[y1 * w + x0];
      p11 = texel_mirror[y1 * w + x1];
      top     = p00 * (one - tx) + p10 * tx;
      bottom  = p01 * (one - tx) + p11 * tx;
      acc     = top * (one - ty) + bottom * ty;
      rounded = (acc + (longint'(1) <<< 31)) >>> 32;
      if (rounded > one) rounded = one;
      return rounded[TEXEL_W-1:0];
    endfunction

    function void note_input(logic kind, logic [ADDR_W-1:0] addr,
                             logic [TEXEL_W-1:0] value,
                             logic signed [COORD_W-1:0] u,
                             logic signed [COORD_W-1:0] v);
      sample_expect_t e;
      if (kind == KIND_WRITE) begin
        texel_mirror[addr] = (value > ONE_Q16) ? ONE_Q16 : value;
      end else begin
        e.u = u;
        e.v = v;
        e.value = (cur_width == 0 || cur_height == 0) ? ONE_Q16 : filter_sample(u, v);
        pending_samples.push_back(e);
      end
    endfunction

    function void check_result(logic [TEXEL_W-1:0] actual);
      sample_expect_t e;
      if (pending_samples.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected sample result %0d", actual);
      end else begin
        e = pending_samples.pop_front();
        checked++;
        if (actual !== e.value) begin
          failures++;
          if (failures <= 10) begin
            $display("sample mismatch u=%0d v=%0d size %0dx%0d: expected %0d got %0d",
                     e.u, e.v, cur_width, cur_height, e.value, actual);
          end
        end
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic                      in_kind;
  logic [ADDR_W-1:0]         in_texel_address;
  logic [TEXEL_W-1:0]        in_texel_value;
  logic signed [COORD_W-1:0] in_u_coord;
  logic signed [COORD_W-1:0] in_v_coord;
  logic                      out_valid;
  logic                      out_stall;
  logic [TEXEL_W-1:0]        out_sample_value;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [DIM_W-1:0]          cfg_data;

  bilinear_scoreboard board = new();
  bit                 texel_written [TEXEL_CAPACITY];
  int                 sender_idle_pct;
  int                 receiver_stall_pct;
  int                 cycle_count;
  int                 texel_writes;
  int                 size_settings;

  logic [DIM_W-1:0] phase_width  [NUM_PHASES] =
    '{9'd16, 9'd300, 9'd1, 9'd7, 9'd0, 9'd3, 9'd20, 9'd20, 9'd128};
  logic [DIM_W-1:0] phase_height [NUM_PHASES] =
    '{9'd16, 9'd1, 9'd511, 9'd13, 9'd9, 9'd80, 9'd12, 9'd20, 9'd2};

  bilinear_texture_sampler_core DUT (.*);

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < receiver_stall_pct);
  end

  // Handshakes are sampled here before the block's registers update.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end else if (rst_n) begin
      if (out_valid && !out_stall) board.check_result(out_sample_value);
      if (in_valid && !in_stall) begin
        board.note_input(in_kind, in_texel_address, in_texel_value, in_u_coord, in_v_coord);
      end
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 49; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 49; end
      default: begin sender_idle_pct = 8; receiver_stall_pct = 8; end
    endcase
  endtask

  task automatic send_item(input logic kind, input logic [ADDR_W-1:0] addr,
                           input logic [TEXEL_W-1:0] value,
                           input logic signed [COORD_W-1:0] u,
                           input logic signed [COORD_W-1:0] v);
    if ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk) in_valid = 1'b0;
      repeat ($urandom_range(2)) @(negedge clk);
    end
    @(negedge clk);
    in_valid         = 1'b1;
    in_kind          = kind;
    in_texel_address = addr;
    in_texel_value   = value;
    in_u_coord       = u;
    in_v_coord       = v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_write(input logic [ADDR_W-1:0] addr, input logic [TEXEL_W-1:0] value);
    texel_written[addr] = 1'b1;
    texel_writes++;
    send_item(KIND_WRITE, addr, value, COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_sample(input logic signed [COORD_W-1:0] u,
                             input logic signed [COORD_W-1:0] v);
    send_item(KIND_SAMPLE, ADDR_W'($urandom), TEXEL_W'($urandom), u, v);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [DIM_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    board.set_size(index, data);
    size_settings++;
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // Texel writes give no result, so wait out the pipeline after the last sample.
  task automatic wait_drained();
    @(negedge clk) in_valid = 1'b0;
    while (board.pending_samples.size() != 0) @(posedge clk);
    repeat (NUM_STAGES + 4) @(posedge clk);
  endtask

  function automatic logic [TEXEL_W-1:0] random_texel();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return ONE_Q16;
    if (r < 20) return TEXEL_W'($urandom_range(65537, 131071));
    if (r < 25) return '0;
    return TEXEL_W'($urandom_range(65536));
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(input int unsigned size);
    int unsigned span;
    int unsigned r;
    int          c;
    span = (size == 0) ? 1 : size;
    r = $urandom_range(99);
    if (r < 50) begin
      c = $urandom_range(65536);
    end else if (r < 70) begin
      c = int'($urandom_range(81920)) - 8192;
    end else if (r < 80) begin
      c = (($urandom_range(span - 1) * 2 + 1) * 32768) / span;
    end else if (r < 85) begin
      c = $urandom_range(1) ? 0 : 65536;
    end else begin
      c = $urandom;
    end
    return c[COORD_W-1:0];
  endfunction

  // Every texel a sample can reach must hold a value before it is read.
  task automatic fill_texture();
    int unsigned area;
    area = board.cur_width * board.cur_height;
    for (int unsigned a = 0; a < area; a++) begin
      if (!texel_written[a]) send_write(a[ADDR_W-1:0], random_texel());
    end
  endtask

  task automatic random_item();
    int unsigned area;
    logic [ADDR_W-1:0] addr;
    area = board.cur_width * board.cur_height;
    if ($urandom_range(99) < 65) begin
      send_sample(rand_coord(board.cur_width), rand_coord(board.cur_height));
    end else begin
      if (area != 0 && $urandom_range(99) < 80) addr = ADDR_W'($urandom_range(area - 1));
      else addr = ADDR_W'($urandom);
      send_write(addr, random_texel());
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_kind          = KIND_WRITE;
    in_texel_address = '0;
    in_texel_value   = '0;
    in_u_coord       = '0;
    in_v_coord       = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_TEXTURE_WIDTH;
    cfg_data         = '0;
    set_idling(0);
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // No texture loaded yet, so every sample returns one.
    send_sample('0, '0);
    send_sample(20'sh80000, 20'sh7FFFF);
    send_write(16'hFFFF, 17'h1FFFF);
    send_write('0, '0);
    wait_drained();
    write_register(CFG_TEXTURE_WIDTH, 9'h1FF);
    send_sample(20'sd32768, 20'sd32768);

    // Widest texture, one row high.
    wait_drained();
    write_register(CFG_TEXTURE_HEIGHT, 9'd1);
    fill_texture();
    send_write(16'd0, ONE_Q16);
    send_write(16'd255, ONE_Q16);
    send_write(16'd7, 17'h1FFFF);
    send_sample('0, '0);
    send_sample(20'sd65536, '0);
    send_sample(20'sh80000, 20'sh7FFFF);
    send_sample(20'sh7FFFF, 20'sh80000);
    send_sample(20'sd1920, '0);
    send_sample(20'sd1984, 20'sd32768);

    // One column, tallest texture.
    wait_drained();
    write_register(CFG_TEXTURE_WIDTH, 9'd1);
    write_register(CFG_TEXTURE_HEIGHT, 9'd300);
    fill_texture();
    send_sample('0, '0);
    send_sample('0, 20'sd65536);
    send_sample(20'sd32768, 20'sh80000);
    send_sample('0, 20'sh7FFFF);

    phase_width[7]  = DIM_W'($urandom_range(1, 16));
    phase_height[7] = DIM_W'($urandom_range(1, 16));
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idling(p % 4);
      wait_drained();
      write_register(CFG_TEXTURE_WIDTH, phase_width[p]);
      write_register(CFG_TEXTURE_HEIGHT, phase_height[p]);
      fill_texture();
      repeat (RANDOM_PER_PHASE) random_item();
    end

    set_idling(0);
    wait_drained();
    $display("tb: %0d samples checked against %0d texel writes", board.checked, texel_writes);
    $display("tb: %0d size register writes over %0d cycles", size_settings, cycle_count);
    if (board.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches", board.failures);
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/bts_pkg.sv
hdl/bts_ram.sv
hdl/bilinear_texture_sampler_core.sv
hdl/bts_checker.sv
sim/bilinear_texture_sampler_core_tb.sv
